>>> hdl/led_driver_command_shadow_top_defines.svh
// Assertion macros for the file that checks its own logic.
`ifndef LED_DRIVER_COMMAND_SHADOW_TOP_DEFINES_SVH
`define LED_DRIVER_COMMAND_SHADOW_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LDCS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LDCS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ldcs_pkg.sv
package ldcs_pkg;

    localparam int NUM_LEDS = 16;
    localparam int NUM_MODE_BYTES = 4;

    localparam logic [1:0] KIND_BRIGHT = 2'd0;
    localparam logic [1:0] KIND_CURRENT = 2'd1;
    localparam logic [1:0] KIND_FAULT = 2'd2;
    localparam logic [1:0] KIND_QUERY = 2'd3;

    localparam logic [6:0] MODE_REG_BASE = 7'h02;
    localparam logic [6:0] PWM_REG_BASE = 7'h08;
    localparam logic [6:0] IREF_REG_BASE = 7'h18;

    localparam logic [7:0] FULL_ON_ABOVE = 8'd247;
    localparam logic [7:0] PWM_ABOVE = 8'd8;
    localparam logic [1:0] MODE_OFF = 2'b00;
    localparam logic [1:0] MODE_FULL = 2'b01;
    localparam logic [1:0] MODE_PWM = 2'b10;

    localparam logic [1:0] FLAG_SHORT = 2'b01;
    localparam logic [1:0] FLAG_OPEN = 2'b10;

    localparam logic [15:0] MAX_CURRENT_RESET = 16'd918;
    // Full scale is 57.375 mA in 1/16 mA units; code = c * 85 / 306 below it.
    localparam logic [15:0] IREF_SPAN_Q4 = 16'd918;
    localparam logic [6:0] IREF_NUM = 7'd85;
    localparam logic [8:0] IREF_DEN = 9'd306;
    localparam logic [15:0] IREF_RECIP = 16'd54827;
    localparam int IREF_SHIFT = 24;
    localparam logic [7:0] CODE_MAX = 8'd255;

    typedef enum logic [1:0] {
        ST_NORMAL = 2'd0,
        ST_SHORT = 2'd1,
        ST_OPEN = 2'd2
    } led_st_t;

    typedef struct packed {
        logic flagged;
        led_st_t st_next;
    } lane_rpt_t;

    typedef struct packed {
        logic over_temp;
        logic any_fault;
        logic any_open;
        logic any_short;
    } flt_sum_t;

endpackage

>>> hdl/ldcs_lane.sv
module ldcs_lane
    import ldcs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       upd_en,
    input  logic [1:0] flag,
    input  logic       mode_on,
    output led_st_t    st,
    output lane_rpt_t  rpt
);

    led_st_t st_reg;
    led_st_t st_next;

    always_comb begin
        st_next = st_reg;
        if (upd_en) begin
            priority if (flag == FLAG_SHORT) begin
                st_next = ST_SHORT;
            end else if (flag == FLAG_OPEN) begin
                st_next = ST_OPEN;
            end else if (mode_on) begin
                st_next = ST_NORMAL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_NORMAL;
        end else begin
            st_reg <= st_next;
        end
    end

    assign st = st_reg;
    assign rpt.st_next = st_next;
    assign rpt.flagged = upd_en && (flag == FLAG_SHORT || flag == FLAG_OPEN);

endmodule

>>> hdl/ldcs_merge.sv
module ldcs_merge
    import ldcs_pkg::*;
(
    input  lane_rpt_t rpt [NUM_LEDS],
    input  logic      over_temp,
    output flt_sum_t  sum
);

    logic flag_any;
    logic open_any;
    logic short_any;

    always_comb begin
        flag_any = 1'b0;
        open_any = 1'b0;
        short_any = 1'b0;
        for (int i = 0; i < NUM_LEDS; i++) begin
            flag_any = flag_any | rpt[i].flagged;
            open_any = open_any | (rpt[i].st_next == ST_OPEN);
            short_any = short_any | (rpt[i].st_next == ST_SHORT);
        end
        sum.over_temp = over_temp;
        sum.any_fault = over_temp | flag_any;
        sum.any_open = sum.any_fault & open_any;
        sum.any_short = sum.any_fault & short_any;
    end

endmodule

>>> hdl/led_driver_command_shadow_top.sv
// Command front end for a 16-channel LED driver. Each item is one command and
// passes the p1, p2 and output registers before its first result shows. While
// the output is not stalled a new item can be accepted every cycle and items
// other than brightness run at one item a cycle; a brightness item holds the p2
// stage until its mode write and then its PWM write have left through the one
// output register in turn, so p2 takes no next item before both have gone. The
// shadow mode bytes and the sixteen per-channel status lanes are updated in the
// cycle an item is accepted, so queries and fault reports always see earlier items.
// The current code comes from a reciprocal multiply and a one-step correction
// spread over the two pipeline stages.
`include "led_driver_command_shadow_top_defines.svh"

module led_driver_command_shadow_top
    import ldcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [3:0]  s_led,
    input  logic [7:0]  s_brightness,
    input  logic [15:0] s_current_q4,
    input  logic [7:0]  s_mode_two,
    input  logic [31:0] s_fault_flags,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_is_write,
    output logic [6:0]  m_reg_addr,
    output logic [7:0]  m_reg_data,
    output logic        m_over_temp,
    output logic        m_any_fault,
    output logic        m_any_open,
    output logic        m_any_short,
    output logic [1:0]  m_led_status,
    output logic        m_last
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  led;
        logic [7:0]  bright;
        logic [7:0]  mode_byte;
        flt_sum_t    sum;
        led_st_t     st;
        logic        sat;
        logic [16:0] x;
    } stage_t;

    typedef struct packed {
        logic       is_write;
        logic [6:0] reg_addr;
        logic [7:0] reg_data;
        flt_sum_t   sum;
        logic [1:0] led_status;
        logic       last;
    } res_t;

    logic [15:0] max_cur_reg;
    logic [7:0]  shadow_reg [NUM_MODE_BYTES];

    logic   p1_valid_reg;
    stage_t p1_reg;
    logic   p2_valid_reg;
    logic   p2_phase_reg;
    stage_t p2_reg;
    logic [7:0] p2_q0_reg;
    logic   m_valid_reg;
    res_t   res_reg;

    logic      accept;
    logic      out_free;
    logic      p2_single;
    logic      p2_pop;
    logic      p2_ready;
    logic      p1_pop;
    logic      fault_upd;

    led_st_t   lane_st [NUM_LEDS];
    lane_rpt_t lane_rpt [NUM_LEDS];
    flt_sum_t  sum_now;

    logic [1:0]  mode_bits;
    logic [7:0]  mode_byte_next;
    logic [15:0] cur_clamped;
    stage_t      p1_next;
    logic [32:0] recip_prod;
    logic [16:0] q0_times_den;
    logic [16:0] rem;
    logic [7:0]  code;
    res_t        res_next;

    assign accept = s_valid && s_ready;
    assign fault_upd = accept && (s_kind == KIND_FAULT) && s_mode_two[6];

    for (genvar i = 0; i < NUM_LEDS; i++) begin : g_lane
        ldcs_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .upd_en  (fault_upd),
            .flag    (s_fault_flags[2*i +: 2]),
            .mode_on (shadow_reg[i / 4][2*(i % 4) +: 2] != MODE_OFF),
            .st      (lane_st[i]),
            .rpt     (lane_rpt[i])
        );
    end

    ldcs_merge u_merge (
        .rpt       (lane_rpt),
        .over_temp (s_mode_two[7]),
        .sum       (sum_now)
    );

    always_comb begin
        priority if (s_brightness > FULL_ON_ABOVE) begin
            mode_bits = MODE_FULL;
        end else if (s_brightness > PWM_ABOVE) begin
            mode_bits = MODE_PWM;
        end else begin
            mode_bits = MODE_OFF;
        end
        mode_byte_next = shadow_reg[s_led[3:2]];
        mode_byte_next[{s_led[1:0], 1'b0} +: 2] = mode_bits;

        cur_clamped = (s_current_q4 > max_cur_reg) ? max_cur_reg : s_current_q4;

        p1_next.kind = s_kind;
        p1_next.led = s_led;
        p1_next.bright = s_brightness;
        p1_next.mode_byte = mode_byte_next;
        p1_next.sum = sum_now;
        p1_next.st = lane_st[s_led];
        p1_next.sat = (cur_clamped >= IREF_SPAN_Q4);
        p1_next.x = 17'(cur_clamped[9:0] * IREF_NUM);
    end

    // Stage handshake and input ready control.
    assign out_free = !m_valid_reg || m_ready;
    assign p2_single = (p2_reg.kind != KIND_BRIGHT) || p2_phase_reg;
    assign p2_pop = p2_valid_reg && out_free && p2_single;
    assign p2_ready = !p2_valid_reg || p2_pop;
    assign p1_pop = p1_valid_reg && p2_ready;
    assign s_ready = !p1_valid_reg || p1_pop;

    assign recip_prod = 33'(p1_reg.x) * 33'(IREF_RECIP);

    always_comb begin
        q0_times_den = 17'(p2_q0_reg * IREF_DEN);
        rem = p2_reg.x - q0_times_den;
        priority if (p2_reg.sat) begin
            code = CODE_MAX;
        end else if (rem >= 17'(IREF_DEN)) begin
            code = p2_q0_reg + 8'd1;
        end else begin
            code = p2_q0_reg;
        end

        res_next = '0;
        res_next.last = 1'b1;
        unique case (p2_reg.kind)
            KIND_BRIGHT: begin
                res_next.is_write = 1'b1;
                if (p2_phase_reg) begin
                    res_next.reg_addr = PWM_REG_BASE + 7'(p2_reg.led);
                    res_next.reg_data = p2_reg.bright;
                end else begin
                    res_next.reg_addr = MODE_REG_BASE + 7'(p2_reg.led[3:2]);
                    res_next.reg_data = p2_reg.mode_byte;
                    res_next.last = 1'b0;
                end
            end
            KIND_CURRENT: begin
                res_next.is_write = 1'b1;
                res_next.reg_addr = IREF_REG_BASE + 7'(p2_reg.led);
                res_next.reg_data = code;
            end
            KIND_FAULT: begin
                res_next.sum = p2_reg.sum;
            end
            KIND_QUERY: begin
                res_next.led_status = p2_reg.st;
            end
            default: begin
                res_next.last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_cur_reg <= MAX_CURRENT_RESET;
            for (int k = 0; k < NUM_MODE_BYTES; k++) begin
                shadow_reg[k] <= '0;
            end
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p2_phase_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_cur_reg <= cfg_wr_data;
            end
            if (accept && s_kind == KIND_BRIGHT) begin
                shadow_reg[s_led[3:2]] <= mode_byte_next;
            end
            if (s_ready) begin
                p1_valid_reg <= s_valid;
            end
            if (p2_ready) begin
                p2_valid_reg <= p1_valid_reg;
                p2_phase_reg <= 1'b0;
            end else if (out_free) begin
                p2_phase_reg <= 1'b1;
            end
            if (out_free) begin
                m_valid_reg <= p2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_reg <= p1_next;
        end
        if (p1_pop) begin
            p2_reg <= p1_reg;
            p2_q0_reg <= recip_prod[IREF_SHIFT +: 8];
        end
        if (out_free && p2_valid_reg) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_is_write = res_reg.is_write;
    assign m_reg_addr = res_reg.reg_addr;
    assign m_reg_data = res_reg.reg_data;
    assign m_over_temp = res_reg.sum.over_temp;
    assign m_any_fault = res_reg.sum.any_fault;
    assign m_any_open = res_reg.sum.any_open;
    assign m_any_short = res_reg.sum.any_short;
    assign m_led_status = res_reg.led_status;
    assign m_last = res_reg.last;

    `LDCS_ASSERT_NEXT(a_pair_follows, aclk, aresetn, m_valid && m_ready && !m_last, m_valid && m_is_write && m_last, "Second write of a brightness item did not follow.")
    `LDCS_ASSERT_NOW(a_flags_need_fault, aclk, aresetn, m_valid && (m_any_open || m_any_short), m_any_fault && !m_is_write, "Open or short reported without a fault.")
    `LDCS_ASSERT_NOW(a_first_is_mode, aclk, aresetn, m_valid && !m_last, m_is_write && m_reg_addr >= MODE_REG_BASE && m_reg_addr < PWM_REG_BASE, "First of two results is not a mode write.")
    `LDCS_ASSERT_NOW(a_stall_held, aclk, aresetn, !s_ready, p1_valid_reg && p2_valid_reg && (m_valid_reg || !p2_single), "Input stalled with a free stage.")

endmodule

>>> test/ldcs_reply_checker.sv
module ldcs_reply_checker
    import ldcs_pkg::*;
(
    input  logic        clk,
    input  logic        rstn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [3:0]  s_led,
    input  logic [7:0]  s_brightness,
    input  logic [15:0] s_current_q4,
    input  logic [7:0]  s_mode_two,
    input  logic [31:0] s_fault_flags,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_is_write,
    input  logic [6:0]  m_reg_addr,
    input  logic [7:0]  m_reg_data,
    input  logic        m_over_temp,
    input  logic        m_any_fault,
    input  logic        m_any_open,
    input  logic        m_any_short,
    input  logic [1:0]  m_led_status,
    input  logic        m_last,
    output int          fail_count,
    output int          replies_owed
);

    typedef struct packed {
        logic       is_write;
        logic [6:0] reg_addr;
        logic [7:0] reg_data;
        logic       over_temp;
        logic       any_fault;
        logic       any_open;
        logic       any_short;
        logic [1:0] led_status;
        logic       last;
    } led_reply_t;

    logic [7:0]  mode_shadow [NUM_MODE_BYTES];
    led_st_t     channel_state [NUM_LEDS];
    logic [15:0] iref_ceiling;
    led_reply_t  replies_due [$];

    initial begin
        fail_count = 0;
        replies_owed = 0;
    end

    function automatic string reply_text(input led_reply_t r);
        return $sformatf("wr=%0d addr=0x%h data=0x%h ot=%0d flt=%0d open=%0d short=%0d st=%0d last=%0d",
                         r.is_write, r.reg_addr, r.reg_data, r.over_temp, r.any_fault,
                         r.any_open, r.any_short, r.led_status, r.last);
    endfunction

    task automatic decode_command(input logic [1:0] kind, input logic [3:0] led,
                                  input logic [7:0] level, input logic [15:0] current,
                                  input logic [7:0] mode_two, input logic [31:0] flags);
        led_reply_t  r;
        logic [1:0]  mode;
        logic [1:0]  flag;
        logic        fault;
        int unsigned clamped;
        int unsigned code;
        r = '0;
        case (kind)
            KIND_BRIGHT: begin
                if (level > FULL_ON_ABOVE) begin
                    mode = MODE_FULL;
                end else if (level > PWM_ABOVE) begin
                    mode = MODE_PWM;
                end else begin
                    mode = MODE_OFF;
                end
                mode_shadow[led[3:2]][{led[1:0], 1'b0} +: 2] = mode;
                r.is_write = 1'b1;
                r.reg_addr = MODE_REG_BASE + 7'(led[3:2]);
                r.reg_data = mode_shadow[led[3:2]];
                replies_due.push_back(r);
                r.reg_addr = PWM_REG_BASE + 7'(led);
                r.reg_data = level;
                r.last = 1'b1;
                replies_due.push_back(r);
            end
            KIND_CURRENT: begin
                clamped = 32'((current > iref_ceiling) ? iref_ceiling : current);
                code = (clamped * 32'(CODE_MAX)) / 32'(IREF_SPAN_Q4);
                if (code > 32'(CODE_MAX)) begin
                    code = 32'(CODE_MAX);
                end
                r.is_write = 1'b1;
                r.reg_addr = IREF_REG_BASE + 7'(led);
                r.reg_data = code[7:0];
                r.last = 1'b1;
                replies_due.push_back(r);
            end
            KIND_FAULT: begin
                fault = mode_two[7];
                if (mode_two[6]) begin
                    for (int i = 0; i < NUM_LEDS; i++) begin
                        flag = flags[2 * i +: 2];
                        if (flag == FLAG_SHORT) begin
                            channel_state[i] = ST_SHORT;
                            fault = 1'b1;
                        end else if (flag == FLAG_OPEN) begin
                            channel_state[i] = ST_OPEN;
                            fault = 1'b1;
                        end else if (mode_shadow[i >> 2][(i & 3) * 2 +: 2] != MODE_OFF) begin
                            channel_state[i] = ST_NORMAL;
                        end
                    end
                end
                if (fault) begin
                    for (int i = 0; i < NUM_LEDS; i++) begin
                        if (channel_state[i] == ST_OPEN) begin
                            r.any_open = 1'b1;
                        end
                        if (channel_state[i] == ST_SHORT) begin
                            r.any_short = 1'b1;
                        end
                    end
                end
                r.over_temp = mode_two[7];
                r.any_fault = fault;
                r.last = 1'b1;
                replies_due.push_back(r);
            end
            default: begin
                r.led_status = channel_state[led];
                r.last = 1'b1;
                replies_due.push_back(r);
            end
        endcase
    endtask

    always @(posedge clk) begin
        led_reply_t seen;
        led_reply_t wanted;
        if (!rstn) begin
            for (int k = 0; k < NUM_MODE_BYTES; k++) begin
                mode_shadow[k] = '0;
            end
            for (int i = 0; i < NUM_LEDS; i++) begin
                channel_state[i] = ST_NORMAL;
            end
            iref_ceiling = MAX_CURRENT_RESET;
            replies_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                seen = {m_is_write, m_reg_addr, m_reg_data, m_over_temp, m_any_fault,
                        m_any_open, m_any_short, m_led_status, m_last};
                if (replies_due.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("%0t: unexpected item: %s", $realtime, reply_text(seen));
                    end
                    fail_count++;
                end else begin
                    wanted = replies_due.pop_front();
                    if (seen !== wanted) begin
                        if (fail_count < 10) begin
                            $display("%0t: item mismatch\n  expected %s\n  actual   %s",
                                     $realtime, reply_text(wanted), reply_text(seen));
                        end
                        fail_count++;
                    end
                end
            end
            if (cfg_wr_en) begin
                iref_ceiling = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                decode_command(s_kind, s_led, s_brightness, s_current_q4, s_mode_two,
                               s_fault_flags);
            end
        end
        replies_owed = replies_due.size();
    end

endmodule

>>> test/tb_led_driver_command_shadow_top.sv
module tb_led_driver_command_shadow_top;
    import ldcs_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = KIND_QUERY;
    logic [3:0]  s_led = '0;
    logic [7:0]  s_brightness = '0;
    logic [15:0] s_current_q4 = '0;
    logic [7:0]  s_mode_two = '0;
    logic [31:0] s_fault_flags = '0;
    logic        m_valid;
    logic        m_ready = 1'b1;
    logic        m_is_write;
    logic [6:0]  m_reg_addr;
    logic [7:0]  m_reg_data;
    logic        m_over_temp;
    logic        m_any_fault;
    logic        m_any_open;
    logic        m_any_short;
    logic [1:0]  m_led_status;
    logic        m_last;

    int          fail_count;
    int          replies_owed;
    bit          calm = 1'b0;
    int          sink_stall = 0;
    logic [15:0] ceiling = MAX_CURRENT_RESET;
    logic [15:0] ceiling_plan [6];

    always #5 aclk = ~aclk;

    led_driver_command_shadow_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_led(s_led),
        .s_brightness(s_brightness), .s_current_q4(s_current_q4),
        .s_mode_two(s_mode_two), .s_fault_flags(s_fault_flags),
        .m_valid(m_valid), .m_ready(m_ready), .m_is_write(m_is_write),
        .m_reg_addr(m_reg_addr), .m_reg_data(m_reg_data), .m_over_temp(m_over_temp),
        .m_any_fault(m_any_fault), .m_any_open(m_any_open), .m_any_short(m_any_short),
        .m_led_status(m_led_status), .m_last(m_last)
    );

    ldcs_reply_checker chk (
        .clk(aclk), .rstn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_led(s_led),
        .s_brightness(s_brightness), .s_current_q4(s_current_q4),
        .s_mode_two(s_mode_two), .s_fault_flags(s_fault_flags),
        .m_valid(m_valid), .m_ready(m_ready), .m_is_write(m_is_write),
        .m_reg_addr(m_reg_addr), .m_reg_data(m_reg_data), .m_over_temp(m_over_temp),
        .m_any_fault(m_any_fault), .m_any_open(m_any_open), .m_any_short(m_any_short),
        .m_led_status(m_led_status), .m_last(m_last),
        .fail_count(fail_count), .replies_owed(replies_owed)
    );

    always @(negedge aclk) begin
        if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            sink_stall <= $urandom_range(0, 10);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic push_command(input logic [1:0] kind, input logic [3:0] led,
                                input logic [7:0] level, input logic [15:0] current,
                                input logic [7:0] mode_two, input logic [31:0] flags);
        s_valid <= 1'b1;
        s_kind <= kind;
        s_led <= led;
        s_brightness <= level;
        s_current_q4 <= current;
        s_mode_two <= mode_two;
        s_fault_flags <= flags;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        @(negedge aclk);
        while (replies_owed != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic random_command;
        logic [1:0]  kind;
        logic [7:0]  level;
        logic [15:0] current;
        logic [7:0]  mode_two;
        logic [31:0] flags;
        int          near;
        int          lane;
        kind = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0: begin
                level = 8'($urandom_range(0, 12));
            end
            1: begin
                level = 8'($urandom_range(243, 255));
            end
            default: begin
                level = 8'($urandom_range(0, 255));
            end
        endcase
        case ($urandom_range(0, 3))
            0: begin
                current = 16'($urandom_range(0, 1000));
            end
            1: begin
                near = int'(ceiling) + int'($urandom_range(0, 6)) - 3;
                current = (near < 0) ? 16'd0 : (near > 65535) ? 16'hFFFF : 16'(near);
            end
            default: begin
                current = 16'($urandom_range(0, 65535));
            end
        endcase
        mode_two = 8'($urandom_range(0, 255));
        mode_two[6] = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 3))
            0: begin
                flags = '0;
            end
            1: begin
                flags = '0;
                repeat (2) begin
                    lane = $urandom_range(0, NUM_LEDS - 1);
                    flags[2 * lane +: 2] = 2'($urandom_range(1, 2));
                end
            end
            default: begin
                flags = $urandom;
            end
        endcase
        push_command(kind, 4'($urandom_range(0, 15)), level, current, mode_two, flags);
    endtask

    initial begin
        #3000000;
        $display("led_driver_command_shadow_top verification failed");
        $finish;
    end

    initial begin
        ceiling_plan[0] = 16'd0;
        ceiling_plan[1] = 16'hFFFF;
        ceiling_plan[2] = 16'd1;
        ceiling_plan[3] = 16'd918;
        ceiling_plan[4] = 16'($urandom_range(0, 65535));
        ceiling_plan[5] = 16'd17000;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Brightness thresholds, current clamping and fault table corner cases.
        push_command(KIND_BRIGHT, 4'd0, 8'd0, '0, '0, '0);
        push_command(KIND_BRIGHT, 4'd1, 8'd8, '0, '0, '0);
        push_command(KIND_BRIGHT, 4'd2, 8'd9, '0, '0, '0);
        push_command(KIND_BRIGHT, 4'd3, 8'd247, '0, '0, '0);
        push_command(KIND_BRIGHT, 4'd4, 8'd248, '0, '0, '0);
        push_command(KIND_BRIGHT, 4'd15, 8'd255, '0, '0, '0);
        push_command(KIND_BRIGHT, 4'd7, 8'd128, '0, '0, '0);
        push_command(KIND_CURRENT, 4'd0, '0, 16'd0, '0, '0);
        push_command(KIND_CURRENT, 4'd3, '0, 16'd918, '0, '0);
        push_command(KIND_CURRENT, 4'd9, '0, 16'd917, '0, '0);
        push_command(KIND_CURRENT, 4'd15, '0, 16'hFFFF, '0, '0);
        push_command(KIND_FAULT, '0, '0, '0, 8'h40, 32'h0000_0000);
        push_command(KIND_FAULT, '0, '0, '0, 8'h40, 32'h5555_5555);
        push_command(KIND_QUERY, 4'd15, '0, '0, '0, '0);
        push_command(KIND_FAULT, '0, '0, '0, 8'hC0, 32'hAAAA_AAAA);
        push_command(KIND_QUERY, 4'd3, '0, '0, '0, '0);
        push_command(KIND_FAULT, '0, '0, '0, 8'h80, 32'hFFFF_FFFF);
        push_command(KIND_FAULT, '0, '0, '0, 8'h40, 32'hFFFF_FFFF);
        push_command(KIND_QUERY, 4'd0, '0, '0, '0, '0);
        push_command(KIND_QUERY, 4'd4, '0, '0, '0, '0);
        push_command(KIND_FAULT, '0, '0, '0, 8'h3F, 32'h1234_5678);
        push_command(KIND_QUERY, 4'd1, '0, '0, '0, '0);

        for (int phase = 0; phase < 6; phase++) begin
            drain();
            ceiling = ceiling_plan[phase];
            cfg_wr_en <= 1'b1;
            cfg_wr_data <= ceiling;
            @(negedge aclk);
            cfg_wr_en <= 1'b0;
            calm = (phase == 5);
            repeat (115) begin
                if (!calm && $urandom_range(0, 5) == 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 11)) @(negedge aclk);
                end
                random_command();
            end
        end

        drain();
        repeat (20) @(negedge aclk);
        if (fail_count == 0 && replies_owed == 0) begin
            $display("led_driver_command_shadow_top verification clean");
        end else begin
            $display("led_driver_command_shadow_top verification failed");
        end
        $finish;
    end

endmodule

>>> led_driver_command_shadow_top.f
+incdir+hdl
hdl/ldcs_pkg.sv
hdl/ldcs_lane.sv
hdl/ldcs_merge.sv
hdl/led_driver_command_shadow_top.sv
test/ldcs_reply_checker.sv
test/tb_led_driver_command_shadow_top.sv
